/* hw/rtl/plcm_pkg.sv */
// Package for the piecewise linear color map: widths, codes, table sizes and
// the reset values of the special colors. Used by all files but plcm_ram.
package plcm_pkg;

  localparam int ENTRIES  = 16;
  localparam int EPSILON  = 66;
  localparam int NUM_CH   = 4;
  localparam int NUM_KIND = 5;
  localparam int SLOT_W   = $clog2(ENTRIES);
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int ADDR_W   = 2 + SLOT_W;
  localparam int DEPTH    = NUM_CH * ENTRIES;
  localparam int ENT_W    = 32 + 17 + 32;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  localparam logic [1:0] OP_QUERY   = 2'd0;
  localparam logic [1:0] OP_WR_BP   = 2'd1;
  localparam logic [1:0] OP_WR_SPEC = 2'd2;

  localparam logic [1:0] CLS_FINITE = 2'd0;
  localparam logic [1:0] CLS_NAN    = 2'd1;
  localparam logic [1:0] CLS_PINF   = 2'd2;
  localparam logic [1:0] CLS_NINF   = 2'd3;

  localparam logic [2:0] RG_INTERP = 3'd0;
  localparam logic [2:0] RG_NAN    = 3'd1;
  localparam logic [2:0] RG_PINF   = 3'd2;
  localparam logic [2:0] RG_NINF   = 3'd3;
  localparam logic [2:0] RG_BELOW  = 3'd4;
  localparam logic [2:0] RG_ABOVE  = 3'd5;

  localparam logic CFG_MIN = 1'b0;
  localparam logic CFG_MAX = 1'b1;

  // One classified query in the queue between front and back.
  typedef struct packed {
    logic signed [31:0] sample;
    logic [2:0]         region;
  } query_t;

  function automatic logic [16:0] sat_one(input logic [16:0] v);
    return (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

  function automatic logic [16:0] special_reset(input int kind, input int ch);
    logic [16:0] r;
    r = 17'd0;
    if (ch == 3) r = 17'd32768;
    else case (kind)
      0: r = (ch == 2) ? ONE_Q16 : 17'd0;
      1: r = (ch == 1) ? ONE_Q16 : 17'd0;
      2: r = (ch == 0) ? ONE_Q16 : 17'd0;
      3: r = (ch != 2) ? ONE_Q16 : 17'd0;
      default: r = (ch != 1) ? ONE_Q16 : 17'd0;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/plcm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module plcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/plcm_front.sv */
// Front end: accepts requests, performs table writes and classifies queries
// into a region. Depends on plcm_pkg.
module plcm_front import plcm_pkg::*; (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic [1:0]         value_class,
  input  logic signed [31:0] sample_value,
  input  logic [3:0]         slot,
  input  logic [2:0]         special_kind,
  input  logic [16:0]        intensity,
  input  logic signed [31:0] min_level,
  input  logic signed [31:0] max_level,
  input  logic               q_full,
  input  logic               q_valid,
  input  logic               back_busy,
  output logic               q_push,
  output query_t             q_data,
  output logic               bp_we,
  output logic               spec_we,
  output logic [2:0]         spec_kind,
  output logic [16:0]        spec_val
);
  logic acc;
  logic is_write;

  // A table write must not overtake a query that is still queued or being
  // worked on, so writes wait until the back end has drained.
  assign is_write  = (opcode == OP_WR_BP) || (opcode == OP_WR_SPEC);
  assign in_ready  = !q_full && (!is_write || (!q_valid && !back_busy));
  assign acc       = in_valid && in_ready;
  assign q_push    = acc && (opcode == OP_QUERY);
  assign bp_we     = acc && (opcode == OP_WR_BP) && ({28'd0, slot} < ENTRIES);
  assign spec_we   = acc && (opcode == OP_WR_SPEC) && (special_kind < 3'(NUM_KIND));
  assign spec_kind = special_kind;
  assign spec_val  = sat_one(intensity);

  always_comb begin
    q_data.sample = sample_value;
    unique case (value_class)
      CLS_NAN:  q_data.region = RG_NAN;
      CLS_PINF: q_data.region = RG_PINF;
      CLS_NINF: q_data.region = RG_NINF;
      default: begin
        if (sample_value < min_level)       q_data.region = RG_BELOW;
        else if (sample_value >= max_level) q_data.region = RG_ABOVE;
        else                                q_data.region = RG_INTERP;
      end
    endcase
  end
endmodule

/* hw/rtl/plcm_back.sv */
// Back end: uses special colors or scans RAM channel tables, interpolates and
// clamps, and holds the result until taken. Depends on plcm_pkg, plcm_ram.
module plcm_back import plcm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  query_t             q_data,
  output logic               q_pop,
  output logic               busy,
  input  logic               bp_we,
  input  logic [ADDR_W-1:0]  bp_addr,
  input  logic [ENT_W-1:0]   bp_data,
  input  logic               bp_seg,
  input  logic               bp_vld,
  input  logic               spec_we,
  input  logic [2:0]         spec_kind,
  input  logic [1:0]         spec_ch,
  input  logic [16:0]        spec_val,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [16:0]        col [NUM_CH],
  output logic [2:0]         region,
  output logic [3:0]         miss_mask
);
  typedef enum logic [2:0] {S_IDLE, S_READ, S_CMP, S_PROD, S_SUM, S_OUT} state_t;
  state_t state;

  logic [DEPTH-1:0] seg_f, vld_f;
  logic [16:0] spec [NUM_KIND][NUM_CH];
  logic [1:0]  ch;
  logic [CNT_W-1:0] idx;
  logic [SLOT_W-1:0] hit;
  logic [ADDR_W-1:0] raddr;
  logic [ENT_W-1:0]  rdata;
  logic signed [31:0] samp;
  logic signed [33:0] limit;
  logic signed [32:0] off;
  logic signed [65:0] prod;
  logic signed [17:0] basev;
  logic signed [31:0] slp;
  logic signed [31:0] lvl;
  logic signed [51:0] sum;
  logic done;

  plcm_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(bp_we), .waddr(bp_addr), .wdata(bp_data),
    .raddr(raddr), .rdata(rdata));

  // Read address: once a breakpoint is chosen, read it; else the scan slot.
  assign raddr = (idx == CNT_W'(ENTRIES)) ? {ch, hit} : {ch, idx[SLOT_W-1:0]};
  assign lvl   = rdata[80:49];
  assign q_pop = (state == S_IDLE) && q_valid && (!out_valid || out_ready);
  assign busy  = state != S_IDLE;
  assign done  = (q_pop && q_data.region != RG_INTERP) || (state == S_SUM && ch == 2'd3);

  // Product rounded to Q0.16 (add one half, floor) plus the base intensity.
  assign sum = 52'($signed(prod[65:16])) + 52'(prod[15]) + 52'(basev);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      seg_f <= '0;
      vld_f <= '0;
      for (int k = 0; k < NUM_KIND; k++)
        for (int c = 0; c < NUM_CH; c++)
          spec[k][c] <= special_reset(k, c);
    end else begin
      if (bp_we) begin
        seg_f[bp_addr] <= bp_seg;
        vld_f[bp_addr] <= bp_vld;
      end
      if (spec_we) spec[spec_kind][spec_ch] <= spec_val;
      out_valid <= done || (out_valid && !out_ready);
      unique case (state)
        S_IDLE: if (q_pop) begin
          samp   <= q_data.sample;
          limit  <= 34'(q_data.sample) + 34'(EPSILON);
          region <= q_data.region;
          miss_mask <= 4'd0;
          ch <= 2'd0; idx <= '0;
          if (q_data.region != RG_INTERP) begin
            for (int c = 0; c < NUM_CH; c++)
              col[c] <= spec[q_data.region - 3'd1][c];
          end else state <= S_READ;
        end
        S_READ: state <= S_CMP;  // RAM read latency for raddr
        S_CMP: begin
          if (idx == CNT_W'(ENTRIES)) begin
            // rdata holds the chosen entry now
            slp   <= rdata[31:0] ;
            basev <= {1'b0, rdata[48:32]};
            off   <= 33'(samp) - 33'(signed'(rdata[80:49]));
            state <= S_PROD;
          end else if (!vld_f[{ch, idx[SLOT_W-1:0]}] || 34'(signed'(lvl)) > limit) begin
            if (!vld_f[{ch, idx[SLOT_W-1:0]}] || idx == '0
                || !seg_f[{ch, idx[SLOT_W-1:0] - SLOT_W'(1)}]) begin
              miss_mask[ch] <= 1'b1;
              col[ch] <= 17'd0;
              state <= S_SUM;
              idx <= '1;
            end else begin
              hit <= idx[SLOT_W-1:0] - SLOT_W'(1);
              idx <= CNT_W'(ENTRIES);
              state <= S_READ;
            end
          end else if (idx == CNT_W'(ENTRIES - 1)) begin
            miss_mask[ch] <= 1'b1;
            col[ch] <= 17'd0;
            state <= S_SUM;
            idx <= '1;
          end else begin
            idx <= idx + CNT_W'(1);
            state <= S_READ;
          end
        end
        S_PROD: begin
          prod  <= 66'(slp) * 66'(off);
          state <= S_SUM;
          idx   <= '0;
        end
        S_SUM: begin
          if (idx == '0) begin
            if (sum < 0) col[ch] <= 17'd0;
            else if (sum > 52'(ONE_Q16)) col[ch] <= ONE_Q16;
            else col[ch] <= sum[16:0];
          end
          idx <= '0;
          if (ch == 2'd3) begin
            state <= S_OUT;
          end else begin
            ch <= ch + 2'd1;
            state <= S_READ;
          end
        end
        S_OUT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* hw/rtl/plcm_queue.sv */
// Two-entry queue of classified queries between front and back.
// Depends on plcm_pkg.
module plcm_queue import plcm_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  query_t wdata,
  output logic   full,
  input  logic   pop,
  output logic   valid,
  output query_t rdata
);
  query_t buf_q [2];
  logic   wp, rp;
  logic [1:0] cnt;

  assign full  = cnt == 2'd2;
  assign valid = cnt != 2'd0;
  assign rdata = buf_q[rp];

  always_ff @(posedge clk) begin
    if (push) buf_q[wp] <= wdata;
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop)  rp <= !rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end
endmodule

/* hw/rtl/piecewise_linear_color_map.sv */
// Piecewise linear color map top level: ports, configuration registers,
// front end, query queue and back end. Depends on plcm_pkg and submodules.
//
// s_axis carries requests: query a color, write a breakpoint, or write a
// special color. Writes take effect at acceptance and give no result; a
// write is held off until no query is queued or being worked on.
// m_axis carries one RGBA result for each query, in request order.
// Special regions (NaN, infinities, below min, at/above max) answer the
// cycle after leaving the queue. An interpolated query scans each channel
// from slot 0 with one RAM read per slot. A channel ends on a miss, or
// reads back the chosen entry, multiplies and clamps when it finds one.
// The back end does not take the next query until it has given the result
// and returned to idle, and then only if the result register is free or
// being taken.
// A two-entry queue lets the front keep taking queries while the back is
// busy; the result register holds the color while m_axis_tready is low.
// Reset restores min 0, max 1.0, clears all valid and segment flags and
// loads the default special colors; breakpoint data is undefined until
// written. Configuration writes (index 0 min, 1 max) apply at once.
module piecewise_linear_color_map import plcm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: opcode, value_class, sample_value, channel, slot, level, base,
  // slope, has_segment, entry_valid, special_kind, intensity, zero pad
  input  logic [151:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: red, green, blue, alpha, region, miss_mask, zero pad
  output logic [79:0]  m_axis_tdata
);
  logic signed [31:0] min_level, max_level;
  logic q_full, q_push, q_valid, q_pop, bp_we, spec_we, back_busy;
  query_t q_in, q_out;
  logic [2:0]  spec_kind, region;
  logic [16:0] spec_val;
  logic [16:0] col [NUM_CH];
  logic [3:0]  miss_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_level <= 32'sd0;
      max_level <= 32'sd65536;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MIN) min_level <= cfg_wdata;
      if (cfg_index == CFG_MAX) max_level <= cfg_wdata;
    end
  end

  plcm_front u_front (
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .opcode(s_axis_tdata[1:0]), .value_class(s_axis_tdata[3:2]),
    .sample_value(s_axis_tdata[35:4]),
    .slot(s_axis_tdata[41:38]), .special_kind(s_axis_tdata[127:125]),
    .intensity(s_axis_tdata[144:128]),
    .min_level(min_level), .max_level(max_level), .q_full(q_full),
    .q_valid(q_valid), .back_busy(back_busy),
    .q_push(q_push), .q_data(q_in), .bp_we(bp_we), .spec_we(spec_we),
    .spec_kind(spec_kind), .spec_val(spec_val));

  plcm_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .wdata(q_in), .full(q_full),
    .pop(q_pop), .valid(q_valid), .rdata(q_out));

  plcm_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_data(q_out), .q_pop(q_pop),
    .busy(back_busy),
    .bp_we(bp_we), .bp_addr({s_axis_tdata[37:36], s_axis_tdata[41:38]}),
    .bp_data({s_axis_tdata[73:42], sat_one(s_axis_tdata[90:74]),
              s_axis_tdata[122:91]}),
    .bp_seg(s_axis_tdata[123]), .bp_vld(s_axis_tdata[124]),
    .spec_we(spec_we), .spec_kind(spec_kind), .spec_ch(s_axis_tdata[37:36]),
    .spec_val(spec_val), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .col(col), .region(region), .miss_mask(miss_mask));

  assign m_axis_tdata = {5'd0, miss_mask, region, col[3], col[2], col[1], col[0]};
endmodule

/* hw/rtl/plcm_checker.sv */
// Port-level checker for the color map, bound to the top level.
// Depends on plcm_pkg for the region codes.
module plcm_checker import plcm_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [79:0]  m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");
  a_region: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[70:68] <= RG_ABOVE)
    else $error("bad region code");
  a_miss: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[70:68] != RG_INTERP |-> m_axis_tdata[74:71] == 4'd0)
    else $error("miss bits in special region");
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");
endmodule

bind piecewise_linear_color_map plcm_checker u_chk (
  .clk(clk), .rst(rst), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata));
